// File: sv/c2d_pkg.sv
// Shared widths, register codes and pipeline tag type of the 3x3 convolution block.
package c2d_pkg;

  localparam int KSIZE        = 3;
  localparam int PIX_W        = 16;
  localparam int COEF_W       = 16;
  localparam int PROD_W       = 32;
  localparam int ROWSUM_W     = 34;
  localparam int ACC_W        = 36;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 16;
  localparam int COEF_ROW_W   = 48;
  localparam int ROW_W        = 17;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 48;
  localparam int OUT_TDATA_W  = 40;

  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WIDTH     = 3'd0,
    REG_HEIGHT    = 3'd1,
    REG_COEF_TOP  = 3'd2,
    REG_COEF_MID  = 3'd3,
    REG_COEF_BOT  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic valid;
    logic last;
  } c2d_tag_t;

endpackage

// File: sv/c2d_ram.sv
// Generic single-write, single-read RAM with registered read data.
module c2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/c2d_cell.sv
// One window cell: holds a pixel, passes it to its left neighbour and weights it.
module c2d_cell (
  input  logic                               clk_i,
  input  logic                               shift_en_i,
  input  logic signed [c2d_pkg::PIX_W-1:0]   pix_i,
  output logic signed [c2d_pkg::PIX_W-1:0]   pix_o,
  input  logic                               prod_en_i,
  input  logic                               mask_i,
  input  logic signed [c2d_pkg::COEF_W-1:0]  coef_i,
  output logic signed [c2d_pkg::PROD_W-1:0]  prod_o
);
  import c2d_pkg::*;

  logic signed [PIX_W-1:0]  pix_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] mul;

  assign mul = coef_i * pix_q;

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      pix_q <= pix_i;
    end
    if (prod_en_i) begin
      prod_q <= mask_i ? mul : '0;
    end
  end

  assign pix_o  = pix_q;
  assign prod_o = prod_q;

endmodule

// File: sv/c2d_sum.sv
// Two-level registered adder tree over the nine weighted window cells.
module c2d_sum (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic signed [c2d_pkg::PROD_W-1:0] prod_i [c2d_pkg::KSIZE][c2d_pkg::KSIZE],
  input  c2d_pkg::c2d_tag_t                 tag_i,
  output logic signed [c2d_pkg::ACC_W-1:0]  sum_o,
  output c2d_pkg::c2d_tag_t                 tag_o
);
  import c2d_pkg::*;

  logic signed [ROWSUM_W-1:0] row_sum_q [KSIZE];
  logic signed [ACC_W-1:0]    total_q;
  c2d_tag_t                   tag_row_q;
  c2d_tag_t                   tag_total_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < KSIZE; i++) begin
        row_sum_q[i] <= ROWSUM_W'(prod_i[i][0]) + ROWSUM_W'(prod_i[i][1])
                      + ROWSUM_W'(prod_i[i][2]);
      end
      total_q <= ACC_W'(row_sum_q[0]) + ACC_W'(row_sum_q[1]) + ACC_W'(row_sum_q[2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_row_q   <= '0;
      tag_total_q <= '0;
    end else if (en_i) begin
      tag_row_q   <= tag_i;
      tag_total_q <= tag_row_q;
    end
  end

  assign sum_o = total_q;
  assign tag_o = tag_total_q;

endmodule

// File: sv/c2d_skid.sv
// Two-entry output stage; its ready is a register so the pipeline never sees m_axis_tready.
module c2d_skid (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  c2d_pkg::c2d_tag_t                tag_i,
  input  logic [c2d_pkg::ACC_W-1:0]        data_i,
  output logic                             ready_o,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic [c2d_pkg::ACC_W-1:0]        data_o,
  output logic                             last_o
);
  import c2d_pkg::*;

  logic             out_v_q, spare_v_q;
  logic [ACC_W-1:0] out_d_q, spare_d_q;
  logic             out_l_q, spare_l_q;
  logic             push, pop;

  assign ready_o = !spare_v_q;
  assign push    = tag_i.valid && !spare_v_q;
  assign pop     = out_v_q && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q   <= 1'b0;
      spare_v_q <= 1'b0;
    end else if (spare_v_q) begin
      if (pop) begin
        spare_v_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_v_q || pop) begin
        out_v_q <= 1'b1;
      end else begin
        spare_v_q <= 1'b1;
      end
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (spare_v_q) begin
      if (pop) begin
        out_d_q <= spare_d_q;
        out_l_q <= spare_l_q;
      end
    end else if (push) begin
      if (!out_v_q || pop) begin
        out_d_q <= data_i;
        out_l_q <= tag_i.last;
      end else begin
        spare_d_q <= data_i;
        spare_l_q <= tag_i.last;
      end
    end
  end

  assign valid_o = out_v_q;
  assign data_o  = out_d_q;
  assign last_o  = out_l_q;

  a_spare_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    spare_v_q |-> out_v_q)
    else $error("spare entry held while output register empty");

  a_spare_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    spare_v_q && !ready_i |=> spare_v_q && out_v_q)
    else $error("buffered beat dropped while output stalled");

endmodule

// File: sv/conv2d_3x3_zero_pad.sv
// Streaming 3x3 correlation with zero padding: counters, line store, cell chain and output.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tdata: pixel; tuser: opcode
//   m_axis    out  m_axis_tvalid/m_axis_tready  tdata: filtered (+4 zero bits); tlast: frame_end
//   cfg       in   cfg_we_i (no ready)          cfg_addr_i register index, cfg_wdata_i
//
// One beat is taken per clock while s_axis_tready is high. The cell chain, two adder levels
// and the output stage are the pipeline. The line store is one RAM read a column ahead, with
// a forward path when the same column is written and read. Reset loads the default settings
// and clears counters and pipeline flags; the line store needs no clearing pass.
// s_axis_tready is low only while the output stage holds two results, which happens when
// m_axis_tready stays low.
module conv2d_3x3_zero_pad #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [c2d_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [c2d_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [c2d_pkg::PIX_W-1:0]          s_axis_tdata,   // [15:0] pixel
  input  logic [0:0]                         s_axis_tuser,   // [0] opcode
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [c2d_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [35:0] filtered, [39:36] zero
  output logic                               m_axis_tlast
);
  import c2d_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  // Configuration registers
  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  logic [COEF_ROW_W-1:0]   coef_q [KSIZE];

  // Position counters and control
  logic [CW-1:0]        col_q, col_d, rd_addr;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [WW-1:0]        w_eff, col_plus, ocol;
  logic [HEIGHT_REG_W-1:0] h_eff;
  logic [ROW_W-1:0]     orow;
  logic                 pipe_en, acc, frame_end_now, pos_valid, wrap;
  logic                 m_top, m_bot, m_left, m_right;
  logic [KSIZE-1:0]     row_mask_q, col_mask_q;
  c2d_tag_t             tag0_q, tag1_q, tag_sum;

  // Line store and column vector
  logic signed [PIX_W-1:0] sample;
  logic [2*PIX_W-1:0]      ram_wdata, ram_rdata, col_vec, fwd_data_q;
  logic                    fwd_q;
  logic signed [PIX_W-1:0] new_col [KSIZE];

  // Cell chain
  logic signed [PIX_W-1:0]  pix      [KSIZE][KSIZE];
  logic signed [PIX_W-1:0]  chain_in [KSIZE][KSIZE];
  logic signed [PROD_W-1:0] prod     [KSIZE][KSIZE];
  logic signed [ACC_W-1:0]  sum;
  logic [ACC_W-1:0]         out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WIDTH_REG_W'(640);
      height_q  <= HEIGHT_REG_W'(480);
      coef_q[0] <= '0;
      coef_q[1] <= '0;
      coef_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_WIDTH:    width_q   <= cfg_wdata_i[WIDTH_REG_W-1:0];
        REG_HEIGHT:   height_q  <= cfg_wdata_i[HEIGHT_REG_W-1:0];
        REG_COEF_TOP: coef_q[0] <= cfg_wdata_i;
        REG_COEF_MID: coef_q[1] <= cfg_wdata_i;
        REG_COEF_BOT: coef_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(width_q) < 3) begin
      w_eff = WW'(3);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
  end

  assign h_eff = (height_q == '0) ? HEIGHT_REG_W'(1) : height_q;

  assign acc           = s_axis_tvalid && pipe_en;
  assign s_axis_tready = pipe_en;

  assign frame_end_now = row_q >= (ROW_W'(h_eff) + ROW_W'(1));
  assign col_plus      = WW'(col_q) + WW'(1);
  assign wrap          = col_plus >= w_eff;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (frame_end_now) begin
      col_d = '0;
      row_d = '0;
    end else if (wrap) begin
      col_d = '0;
      row_d = row_q + ROW_W'(1);
    end else begin
      col_d = col_plus[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // The output position trails the input by one row and one column.
  assign pos_valid = (row_q >= ROW_W'(2)) || (row_q == ROW_W'(1) && col_q != '0);
  assign orow      = (col_q != '0) ? row_q - ROW_W'(1) : row_q - ROW_W'(2);
  assign ocol      = (col_q != '0) ? WW'(col_q) - WW'(1) : w_eff - WW'(1);
  assign m_top     = orow != '0;
  assign m_bot     = (orow + ROW_W'(1)) < ROW_W'(h_eff);
  assign m_left    = ocol != '0;
  assign m_right   = (ocol + WW'(1)) < w_eff;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      row_mask_q <= {m_bot, 1'b1, m_top};
      col_mask_q <= {m_right, 1'b1, m_left};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag0_q <= '0;
      tag1_q <= '0;
    end else if (pipe_en) begin
      tag0_q.valid <= acc && pos_valid;
      tag0_q.last  <= acc && pos_valid && frame_end_now;
      tag1_q       <= tag0_q;
    end
  end

  // Line store: each entry holds {two rows up, one row up} for its column.
  assign sample    = (s_axis_tuser[0] == OP_DRAIN) ? '0 : s_axis_tdata;
  assign rd_addr   = acc ? col_d : col_q;
  assign col_vec   = fwd_q ? fwd_data_q : ram_rdata;
  assign ram_wdata = {col_vec[PIX_W-1:0], sample};

  c2d_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (acc),
    .waddr_i (col_q),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // A read of the column being written this cycle takes the new data instead.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= acc && (rd_addr == col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= ram_wdata;
  end

  assign new_col[0] = col_vec[2*PIX_W-1:PIX_W];
  assign new_col[1] = col_vec[PIX_W-1:0];
  assign new_col[2] = sample;

  for (genvar i = 0; i < KSIZE; i++) begin : g_row
    for (genvar j = 0; j < KSIZE; j++) begin : g_col
      if (j == KSIZE - 1) begin : g_entry
        assign chain_in[i][j] = new_col[i];
      end else begin : g_link
        assign chain_in[i][j] = pix[i][j+1];
      end

      c2d_cell u_cell (
        .clk_i      (clk_i),
        .shift_en_i (acc),
        .pix_i      (chain_in[i][j]),
        .pix_o      (pix[i][j]),
        .prod_en_i  (pipe_en),
        .mask_i     (row_mask_q[i] && col_mask_q[j]),
        .coef_i     (coef_q[i][COEF_W*j +: COEF_W]),
        .prod_o     (prod[i][j])
      );
    end
  end

  c2d_sum u_sum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .prod_i (prod),
    .tag_i  (tag1_q),
    .sum_o  (sum),
    .tag_o  (tag_sum)
  );

  c2d_skid u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (tag_sum),
    .data_i  (sum),
    .ready_o (pipe_en),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_data),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - ACC_W){1'b0}}, out_data};

  a_frame_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && frame_end_now |=> col_q == '0 && row_q == '0)
    else $error("position counters did not restart after frame end");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(tag0_q) && $stable(tag1_q))
    else $error("pipeline tags moved while output stage full");

  a_last_is_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_sum.last |-> tag_sum.valid)
    else $error("frame end flag on an empty pipeline slot");

endmodule

// File: test/tb_conv2d_3x3_zero_pad.sv
// Self-checking testbench of the streaming 3x3 zero-padded convolution block.
`timescale 1ns / 1ps

module tb_conv2d_3x3_zero_pad;
  import c2d_pkg::*;

  localparam int MAX_W = 1024;
  localparam int CLK_HALF = 6;
  localparam int IDLE_PCT = 28;
  localparam int QUIET_CYCLES = 8;
  localparam int RAND_ITEMS = 200;
  localparam int TIMEOUT_NS = 400_000 * 2 * CLK_HALF;
  localparam int N_DIRECTED = 23;

  localparam logic OP_PIXEL = 1'b0;

  localparam logic [1:0] SET_NONE = 2'd0;
  localparam logic [1:0] SET_CENTRE = 2'd1;
  localparam logic [1:0] SET_EXTREME = 2'd2;

  typedef struct packed {
    logic [ACC_W-1:0] filtered;
    logic             frame_end;
  } conv_out_t;

  typedef struct packed {
    logic [1:0]       setting;
    logic             opcode;
    logic [PIX_W-1:0] pixel;
    logic             typed;
    logic             has_out;
    logic [ACC_W-1:0] filtered;
    logic             frame_end;
  } stim_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [PIX_W-1:0]       s_axis_tdata = '0;   // [15:0] pixel
  logic [0:0]             s_axis_tuser = '0;   // [0] opcode
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [35:0] filtered, [39:36] zero
  logic                   m_axis_tlast;

  // Own copy of the block's registers and storage.
  logic [WIDTH_REG_W-1:0]  img_width;
  logic [HEIGHT_REG_W-1:0] img_height;
  logic [COEF_ROW_W-1:0]   coef_row [KSIZE];
  logic signed [PIX_W-1:0] line_above [MAX_W];
  logic signed [PIX_W-1:0] line_above2 [MAX_W];
  logic signed [PIX_W-1:0] win [KSIZE][KSIZE];
  int                      col_pos;
  int                      row_pos;

  conv_out_t   pending_sums [$];
  int unsigned mismatches = 0;
  bit          steady = 1'b0;
  stim_row_t   directed [N_DIRECTED];

  conv2d_3x3_zero_pad #(
    .MAX_WIDTH(MAX_W)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_addr_i(cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  always #CLK_HALF clk_i = ~clk_i;

  function automatic int eff_width();
    int w;
    w = img_width;
    if (w < 3) w = 3;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = img_height;
    if (h < 1) h = 1;
    return h;
  endfunction

  // Advances the window by one beat; returns 1 when the beat completes an output position.
  function automatic bit convolve_beat(input logic op, input logic [PIX_W-1:0] pix,
                                       output conv_out_t res);
    int w, h, c, r, orow, ocol;
    logic signed [PIX_W-1:0] s, top, mid, k;
    longint acc;
    bit live, row_in, col_in;
    w = eff_width();
    h = eff_height();
    c = (col_pos < MAX_W) ? col_pos : MAX_W - 1;
    r = row_pos;
    s = (op == OP_DRAIN) ? '0 : pix;
    top = line_above2[c];
    mid = line_above[c];
    line_above2[c] = mid;
    line_above[c] = s;
    for (int i = 0; i < KSIZE; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = s;
    live = (r >= 2) || (r == 1 && c >= 1);
    if (c >= 1) begin
      orow = r - 1;
      ocol = c - 1;
    end else begin
      orow = r - 2;
      ocol = w - 1;
    end
    res.frame_end = (r >= h + 1);
    if (res.frame_end) begin
      row_pos = 0;
      col_pos = 0;
    end else if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end
    // Neighbours outside the image carry no weight.
    acc = 0;
    for (int dr = 0; dr < KSIZE; dr++) begin
      row_in = !((dr == 0 && orow < 1) || (dr == 2 && orow + 1 >= h));
      for (int dc = 0; dc < KSIZE; dc++) begin
        col_in = !((dc == 0 && ocol < 1) || (dc == 2 && ocol + 1 >= w));
        k = coef_row[dr][COEF_W*dc +: COEF_W];
        if (row_in && col_in) acc += longint'(k) * longint'(win[dr][dc]);
      end
    end
    res.filtered = acc[ACC_W-1:0];
    return live;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    if ($urandom_range(99) >= 20) return PIX_W'($urandom_range(0, 65535));
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    if ($urandom_range(99) >= 15) return COEF_W'($urandom_range(0, 65535));
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'h4000;
      default: return 16'hC000;
    endcase
  endfunction

  function automatic logic [COEF_ROW_W-1:0] rand_coef_row();
    return {rand_coef(), rand_coef(), rand_coef()};
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i = 1'b1;
    cfg_addr_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_WIDTH:    img_width = val[WIDTH_REG_W-1:0];
      REG_HEIGHT:   img_height = val[HEIGHT_REG_W-1:0];
      REG_COEF_TOP: coef_row[0] = val;
      REG_COEF_MID: coef_row[1] = val;
      REG_COEF_BOT: coef_row[2] = val;
      default: ;
    endcase
  endtask

  task automatic load_all(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                          input logic [CFG_DATA_W-1:0] top, input logic [CFG_DATA_W-1:0] mid,
                          input logic [CFG_DATA_W-1:0] bot);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_COEF_TOP, top);
    write_reg(REG_COEF_MID, mid);
    write_reg(REG_COEF_BOT, bot);
  endtask

  // Entered and left at a falling edge; valid stays high into the next beat unless a gap follows.
  task automatic send_beat(input logic op, input logic [PIX_W-1:0] pix, input bit typed,
                           input bit has_out, input conv_out_t typed_out);
    conv_out_t res;
    bit got;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = pix;
    s_axis_tuser = op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    got = convolve_beat(op, pix, res);
    if (typed) begin
      got = has_out;
      res = typed_out;
    end
    if (got) pending_sums.push_back(res);
    @(negedge clk_i);
  endtask

  task automatic send_pixel(input logic op, input logic [PIX_W-1:0] pix);
    send_beat(op, pix, 1'b0, 1'b0, '0);
  endtask

  task automatic wait_quiet();
    s_axis_tvalid = 1'b0;
    while (pending_sums.size() != 0) @(negedge clk_i);
    repeat (QUIET_CYCLES) @(negedge clk_i);
  endtask

  task automatic shuffle_setting();
    int pick, w, h;
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'({$urandom, $urandom});
    // A new width is only safe at a frame boundary: mid-frame it would weight stale line entries.
    if (col_pos == 0 && row_pos == 0 && $urandom_range(99) < 70) begin
      pick = $urandom_range(99);
      if (pick < 8) w = $urandom_range(0, 2);
      else if (pick < 16) w = $urandom_range(13, 48);
      else w = $urandom_range(3, 10);
      write_reg(REG_WIDTH, {junk[CFG_DATA_W-1:WIDTH_REG_W], w[WIDTH_REG_W-1:0]});
    end
    if ($urandom_range(99) < 70) begin
      pick = $urandom_range(99);
      if (pick < 8) h = 0;
      else if (pick < 14) h = $urandom_range(7, 20);
      else h = $urandom_range(1, 6);
      write_reg(REG_HEIGHT, {junk[CFG_DATA_W-1:HEIGHT_REG_W], h[HEIGHT_REG_W-1:0]});
    end
    if ($urandom_range(1)) write_reg(REG_COEF_TOP, rand_coef_row());
    if ($urandom_range(1)) write_reg(REG_COEF_MID, rand_coef_row());
    if ($urandom_range(1)) write_reg(REG_COEF_BOT, rand_coef_row());
  endtask

  // Mostly whole frames with their flush; otherwise frames cut short or plain noise.
  task automatic stream_frames(input int frames, input bit clean, inout int count);
    int w, h, npix, ndrain, style;
    for (int f = 0; f < frames; f++) begin
      w = eff_width();
      h = eff_height();
      style = clean ? 0 : $urandom_range(99);
      npix = w * h;
      if (npix > 1100) npix = $urandom_range(2 * w, 12 * w);
      ndrain = w + 1;
      if (style >= 90) begin
        npix = $urandom_range(1, 2 * w);
        ndrain = 0;
      end else if (style >= 78) begin
        npix = $urandom_range(0, npix);
        ndrain = $urandom_range(0, w + 1);
      end
      for (int i = 0; i < npix; i++) begin
        if (style >= 90) send_pixel(1'($urandom_range(1)), rand_pixel());
        else send_pixel(($urandom_range(99) < 5) ? OP_DRAIN : OP_PIXEL, rand_pixel());
      end
      for (int i = 0; i < ndrain; i++) begin
        send_pixel(($urandom_range(99) < 8) ? OP_PIXEL : OP_DRAIN, rand_pixel());
      end
      count += npix + ndrain;
    end
  endtask

  always @(negedge clk_i) begin
    m_axis_tready = steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    conv_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_sums.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with none expected, actual tdata %h tlast %b",
                 $time, m_axis_tdata, m_axis_tlast);
      end else begin
        want = pending_sums.pop_front();
        if (m_axis_tdata !== {{(OUT_TDATA_W-ACC_W){1'b0}}, want.filtered}) begin
          mismatches++;
          $display("%0t: filtered expected %h actual %h", $time, want.filtered, m_axis_tdata);
        end
        if (m_axis_tlast !== want.frame_end) begin
          mismatches++;
          $display("%0t: frame_end expected %b actual %b", $time, want.frame_end, m_axis_tlast);
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_conv2d_3x3_zero_pad failed");
    $finish;
  end

  initial begin
    int rand_items, spare, phase;
    img_width = 11'd640;
    img_height = 16'd480;
    for (int i = 0; i < KSIZE; i++) coef_row[i] = '0;
    for (int i = 0; i < MAX_W; i++) begin
      line_above[i] = '0;
      line_above2[i] = '0;
    end
    for (int i = 0; i < KSIZE; i++) begin
      for (int j = 0; j < KSIZE; j++) win[i][j] = '0;
    end
    col_pos = 0;
    row_pos = 0;

    // Centre tap of 1.0 on a 3x2 image: each result is its pixel times 2^14, width+1 beats late.
    // Covers a flush beat inside the image and a pixel beat inside the flush.
    directed = '{
      '{SET_CENTRE, OP_PIXEL, 16'h7FFF, 1'b1, 1'b0, 36'h0, 1'b0},
      '{SET_NONE,   OP_PIXEL, 16'h8000, 1'b1, 1'b0, 36'h0, 1'b0},
      '{SET_NONE,   OP_DRAIN, 16'h7FFF, 1'b1, 1'b0, 36'h0, 1'b0},
      '{SET_NONE,   OP_PIXEL, 16'h0001, 1'b1, 1'b0, 36'h0, 1'b0},
      '{SET_NONE,   OP_PIXEL, 16'hFFFF, 1'b1, 1'b1, 36'h0_1FFF_C000, 1'b0},
      '{SET_NONE,   OP_PIXEL, 16'h5555, 1'b1, 1'b1, 36'hF_E000_0000, 1'b0},
      '{SET_NONE,   OP_DRAIN, 16'hFFFF, 1'b1, 1'b1, 36'h0, 1'b0},
      '{SET_NONE,   OP_DRAIN, 16'h0000, 1'b1, 1'b1, 36'h0_0000_4000, 1'b0},
      '{SET_NONE,   OP_PIXEL, 16'h1234, 1'b1, 1'b1, 36'hF_FFFF_C000, 1'b0},
      '{SET_NONE,   OP_DRAIN, 16'h0000, 1'b1, 1'b1, 36'h0_1555_4000, 1'b1},
      // Extreme coefficients and pixels on a 3x3 image, checked by the predictor.
      '{SET_EXTREME, OP_PIXEL, 16'h8000, 1'b0, 1'b0, 36'h0, 1'b0},
      '{SET_NONE,    OP_PIXEL, 16'h8000, 1'b0, 1'b0, 36'h0, 1'b0},
      '{SET_NONE,    OP_PIXEL, 16'h8000, 1'b0, 1'b0, 36'h0, 1'b0},
      '{SET_NONE,    OP_PIXEL, 16'h8000, 1'b0, 1'b0, 36'h0, 1'b0},
      '{SET_NONE,    OP_PIXEL, 16'h8000, 1'b0, 1'b0, 36'h0, 1'b0},
      '{SET_NONE,    OP_PIXEL, 16'h8000, 1'b0, 1'b0, 36'h0, 1'b0},
      '{SET_NONE,    OP_PIXEL, 16'h8000, 1'b0, 1'b0, 36'h0, 1'b0},
      '{SET_NONE,    OP_PIXEL, 16'h8000, 1'b0, 1'b0, 36'h0, 1'b0},
      '{SET_NONE,    OP_PIXEL, 16'h7FFF, 1'b0, 1'b0, 36'h0, 1'b0},
      '{SET_NONE,    OP_DRAIN, 16'h0000, 1'b0, 1'b0, 36'h0, 1'b0},
      '{SET_NONE,    OP_PIXEL, 16'h7FFF, 1'b0, 1'b0, 36'h0, 1'b0},
      '{SET_NONE,    OP_DRAIN, 16'hFFFF, 1'b0, 1'b0, 36'h0, 1'b0},
      '{SET_NONE,    OP_DRAIN, 16'h0000, 1'b0, 1'b0, 36'h0, 1'b0}
    };

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) begin
      if (directed[i].setting == SET_CENTRE) begin
        wait_quiet();
        load_all(48'd3, 48'd2, 48'h0, 48'h0000_4000_0000, 48'h0);
      end else if (directed[i].setting == SET_EXTREME) begin
        wait_quiet();
        load_all(48'd3, 48'd3, 48'h8000_8000_8000, 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF);
      end
      send_beat(directed[i].opcode, directed[i].pixel, directed[i].typed,
                directed[i].has_out, {directed[i].filtered, directed[i].frame_end});
    end

    // Widest line, reached by saturating an over-range width, with a zero height. The frame
    // stops a few beats into its second row, so only a narrower width may follow it.
    spare = 0;
    wait_quiet();
    load_all(48'hFFFF_FFFF_FFFF, 48'h0, rand_coef_row(), rand_coef_row(), rand_coef_row());
    steady = 1'b1;
    for (int i = 0; i < MAX_W + 4; i++) send_pixel(OP_PIXEL, rand_pixel());
    steady = 1'b0;

    // Tallest frame with an under-range width; lowering the height mid-frame closes it.
    wait_quiet();
    load_all(48'd1, 48'hFFFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF);
    stream_frames(1, 1'b1, spare);
    wait_quiet();
    write_reg(REG_HEIGHT, 48'd2);
    stream_frames(2, 1'b1, spare);

    rand_items = 0;
    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      wait_quiet();
      shuffle_setting();
      steady = (phase >= 4 && phase < 8);
      stream_frames($urandom_range(1, 3), 1'b0, rand_items);
      phase++;
    end
    steady = 1'b0;
    wait_quiet();

    if (mismatches == 0) begin
      $display("tb_conv2d_3x3_zero_pad passed");
    end else begin
      $display("tb_conv2d_3x3_zero_pad failed");
    end
    $finish;
  end

endmodule
